FILE: rtl/mrgb_pkg.sv
// shared types, constants and helpers for the masked rgb to argb8888 converter
// no dependencies; imported by every module of the block
package mrgb_pkg;

	localparam int PIX_W       = 32;
	localparam int PROD_W      = PIX_W + 8;
	localparam int OUT_W       = 8;
	localparam int CH_N        = 3;
	localparam int SHIFT_W     = $clog2(PIX_W);
	localparam int CNT_W       = $clog2(PIX_W + 1);
	localparam int CFG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	localparam logic [OUT_W-1:0] ALPHA_OPAQUE = 8'hFF;

	localparam logic [PIX_W-1:0] RED_MASK_RST   = 32'h00FF_0000;
	localparam logic [PIX_W-1:0] GREEN_MASK_RST = 32'h0000_FF00;
	localparam logic [PIX_W-1:0] BLUE_MASK_RST  = 32'h0000_00FF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RED_MASK   = 2'd0,
		CFG_GREEN_MASK = 2'd1,
		CFG_BLUE_MASK  = 2'd2
	} cfg_idx_t;

	// per-channel settings, derived once when the mask is written
	typedef struct packed {
		logic [PIX_W-1:0]   mask;
		logic [SHIFT_W-1:0] shift;
		logic [PIX_W-1:0]   divisor;
		logic               none;
	} chan_cfg_t;

	typedef chan_cfg_t [CH_N-1:0] cfg_set_t;

	// classified item between front and back
	typedef struct packed {
		logic [CH_N-1:0][PIX_W-1:0] field;
		logic                       row_end;
		logic                       frame_end;
	} item_t;

	function automatic chan_cfg_t make_cfg(input logic [PIX_W-1:0] mask);
		chan_cfg_t          c;
		logic [PIX_W-1:0]   low_bit;
		logic [CNT_W-1:0]   cnt;
		low_bit = mask & (~mask + 1'b1);
		c.mask  = mask;
		c.shift = '0;
		for (int i = 0; i < PIX_W; i++) begin
			c.shift = c.shift | (low_bit[i] ? SHIFT_W'(i) : SHIFT_W'(0));
		end
		cnt       = CNT_W'($countones(mask));
		c.divisor = ~({PIX_W{1'b1}} << cnt);
		c.none    = (mask == '0);
		return c;
	endfunction

endpackage

FILE: rtl/masked_rgb_to_argb8888.sv
// top level of the masked rgb to argb8888 converter: mask registers,
// front end, item queue and divider back end; depends on mrgb_pkg and all mrgb_* modules
//
// usage
//   input: an item (raw_pixel with its row and frame end markers) is taken
//     at a rising edge where start is high and busy is low
//   output: done is high for exactly one cycle per item, with red_out,
//     green_out, blue_out, alpha_out and the markers valid in that cycle;
//     the receiver cannot hold results off and the back end never waits
//   throughput: one item per clock, sustained
//   path: an item taken at the accepting edge passes one front stage,
//     one queue slot, one stage forming field*255, one stage per bit of the
//     40-bit dividend in the restoring divider, and the output register
//   ordering: results come out in the order the items went in
//   config: cfg_we writes cfg_wdata into the mask picked by cfg_index
//     (red, green, blue); an index past the list is ignored; shift, bit
//     count and divisor are derived at the write, so a new mask applies to
//     the next item; write only while no item is in flight
//   reset: arst_n clears the pipeline valids and the queue, and loads the
//     masks 0x00ff0000, 0x0000ff00, 0x000000ff (standard xrgb8888 layout)
//   busy: only rises if the queue fills, which the free-running back end
//     keeps from happening
module masked_rgb_to_argb8888 (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [31:0]                        raw_pixel,
	input  logic                               row_end_in,
	input  logic                               frame_end_in,
	input  logic                               cfg_we,
	input  logic [mrgb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                        cfg_wdata,
	output logic                               done,
	output logic [7:0]                         red_out,
	output logic [7:0]                         green_out,
	output logic [7:0]                         blue_out,
	output logic [7:0]                         alpha_out,
	output logic                               row_end_out,
	output logic                               frame_end_out
);
	import mrgb_pkg::*;

	// channel settings, each recomputed from its mask on a write
	cfg_set_t cfg_q;

	// front to queue
	logic  push;
	item_t push_item;
	logic  q_full;

	// queue to back
	logic  q_not_empty;
	item_t head_item;
	logic  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[CH_RED]   <= make_cfg(RED_MASK_RST);
			cfg_q[CH_GREEN] <= make_cfg(GREEN_MASK_RST);
			cfg_q[CH_BLUE]  <= make_cfg(BLUE_MASK_RST);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_RED_MASK: begin
					cfg_q[CH_RED] <= make_cfg(cfg_wdata);
				end
				CFG_GREEN_MASK: begin
					cfg_q[CH_GREEN] <= make_cfg(cfg_wdata);
				end
				CFG_BLUE_MASK: begin
					cfg_q[CH_BLUE] <= make_cfg(cfg_wdata);
				end
				default: begin
					// writes past the register list are dropped
				end
			endcase
		end
	end

	mrgb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.raw_pixel    (raw_pixel),
		.row_end_in   (row_end_in),
		.frame_end_in (frame_end_in),
		.cfg          (cfg_q),
		.q_full       (q_full),
		.push         (push),
		.push_item    (push_item)
	);

	mrgb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_item (head_item)
	);

	mrgb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (q_not_empty),
		.in_item       (head_item),
		.cfg           (cfg_q),
		.pop           (pop),
		.done          (done),
		.red_out       (red_out),
		.green_out     (green_out),
		.blue_out      (blue_out),
		.row_end_out   (row_end_out),
		.frame_end_out (frame_end_out)
	);

	// alpha is fixed opaque
	assign alpha_out = ALPHA_OPAQUE;

endmodule

FILE: rtl/mrgb_front.sv
// front end: takes items, masks and aligns the three channel fields
// depends on mrgb_pkg
module mrgb_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [31:0]              raw_pixel,
	input  logic                     row_end_in,
	input  logic                     frame_end_in,
	input  mrgb_pkg::cfg_set_t       cfg,
	input  logic                     q_full,
	output logic                     push,
	output mrgb_pkg::item_t          push_item
);
	import mrgb_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  accept;

	assign busy      = valid_s1 && q_full;
	assign accept    = start && !busy;
	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int c = 0; c < CH_N; c++) begin
				item_s1.field[c] <= (raw_pixel & cfg[c].mask) >> cfg[c].shift;
			end
			item_s1.row_end   <= row_end_in;
			item_s1.frame_end <= frame_end_in;
		end
	end

endmodule

FILE: rtl/mrgb_queue.sv
// short fifo of classified items between front and back
// depends on mrgb_pkg
module mrgb_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mrgb_pkg::item_t     push_item,
	input  logic                pop,
	output logic                full,
	output logic                not_empty,
	output mrgb_pkg::item_t     head_item
);
	import mrgb_pkg::*;

	item_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = slot_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: rtl/mrgb_back.sv
// back end: scales each field by 255 and divides by 2^bits-1 in a
// restoring divider pipeline, one quotient bit per stage; depends on mrgb_pkg
module mrgb_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  mrgb_pkg::item_t         in_item,
	input  mrgb_pkg::cfg_set_t      cfg,
	output logic                    pop,
	output logic                    done,
	output logic [7:0]              red_out,
	output logic [7:0]              green_out,
	output logic [7:0]              blue_out,
	output logic                    row_end_out,
	output logic                    frame_end_out
);
	import mrgb_pkg::*;

	localparam int DIV_STEPS = PROD_W;

	logic [DIV_STEPS:0]              vld_s;
	logic [CH_N-1:0][PIX_W-1:0]      rem_s  [DIV_STEPS+1];
	logic [CH_N-1:0][PROD_W-1:0]     dvd_s  [DIV_STEPS+1];
	logic [CH_N-1:0][OUT_W-1:0]      quo_s  [DIV_STEPS+1];
	logic [1:0]                      mark_s [DIV_STEPS+1];

	logic [CH_N-1:0][PIX_W:0]        trial  [DIV_STEPS];
	logic [CH_N-1:0]                 take   [DIV_STEPS];
	logic [CH_N-1:0][PIX_W-1:0]      rem_nx [DIV_STEPS];

	logic                            done_q;
	logic [CH_N-1:0][OUT_W-1:0]      chan_q;
	logic [1:0]                      mark_q;

	// the back end never stalls, so every queued item is taken at once
	assign pop = in_valid;

	always_comb begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			for (int c = 0; c < CH_N; c++) begin
				trial[k][c]  = {rem_s[k][c], dvd_s[k][c][PROD_W-1]};
				take[k][c]   = (trial[k][c] >= {1'b0, cfg[c].divisor});
				rem_nx[k][c] = take[k][c] ? PIX_W'(trial[k][c] - {1'b0, cfg[c].divisor})
				                          : trial[k][c][PIX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_s  <= {vld_s[DIV_STEPS-1:0], in_valid};
			done_q <= vld_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		// entry stage: field * 255 as (field << 8) - field
		for (int c = 0; c < CH_N; c++) begin
			dvd_s[0][c] <= (PROD_W'(in_item.field[c]) << 8) - PROD_W'(in_item.field[c]);
			rem_s[0][c] <= '0;
			quo_s[0][c] <= '0;
		end
		mark_s[0] <= {in_item.row_end, in_item.frame_end};

		for (int k = 0; k < DIV_STEPS; k++) begin
			for (int c = 0; c < CH_N; c++) begin
				rem_s[k+1][c] <= rem_nx[k][c];
				dvd_s[k+1][c] <= dvd_s[k][c] << 1;
				quo_s[k+1][c] <= {quo_s[k][c][OUT_W-2:0], take[k][c]};
			end
			mark_s[k+1] <= mark_s[k];
		end

		// only the low 8 quotient bits survive; an empty mask gives zero
		for (int c = 0; c < CH_N; c++) begin
			chan_q[c] <= cfg[c].none ? '0 : quo_s[DIV_STEPS][c];
		end
		mark_q <= mark_s[DIV_STEPS];
	end

	assign done          = done_q;
	assign red_out       = chan_q[CH_RED];
	assign green_out     = chan_q[CH_GREEN];
	assign blue_out      = chan_q[CH_BLUE];
	assign row_end_out   = mark_q[1];
	assign frame_end_out = mark_q[0];

endmodule
